// ===== src/sjf_pkg.sv =====
`default_nettype none

package sjf_pkg;

  // Ready store depth and derived widths
  localparam int QUEUE_DEPTH = 16;
  localparam int IdxW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW        = $clog2(QUEUE_DEPTH + 1);

  // Fixed field widths
  localparam int IdW    = 8;
  localparam int BurstW = 16;
  localparam int TimeW  = 16;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_TAKE,
    ST_POST
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [BurstW-1:0] burst;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic [IdxW-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic             running_valid;
    logic [IdW-1:0]   running_id;
    logic             started;
    logic             finished;
    logic [IdW-1:0]   finished_id;
    logic [TimeW-1:0] now;
    logic             dropped;
  } result_t;

  // Circular index step, any depth
  function automatic logic [IdxW-1:0] idx_next(input logic [IdxW-1:0] i);
    logic [IdxW-1:0] r;
    if (i == IdxW'(QUEUE_DEPTH - 1)) r = '0;
    else r = i + IdxW'(1);
    return r;
  endfunction

  function automatic logic [IdxW-1:0] idx_prev(input logic [IdxW-1:0] i);
    logic [IdxW-1:0] r;
    if (i == '0) r = IdxW'(QUEUE_DEPTH - 1);
    else r = i - IdxW'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/sjf_job_if.sv =====
`default_nettype none

interface sjf_job_if import sjf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [IdW-1:0]    job_id;
  logic [BurstW-1:0] burst;

  modport source (output valid, cmd, job_id, burst, input ready);
  modport sink   (input valid, cmd, job_id, burst, output ready);
endinterface

`default_nettype wire

// ===== src/sjf_res_if.sv =====
`default_nettype none

interface sjf_res_if import sjf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             running_valid;
  logic [IdW-1:0]   running_id;
  logic             started;
  logic             finished;
  logic [IdW-1:0]   finished_id;
  logic [TimeW-1:0] now;
  logic             dropped;

  modport source (output valid, running_valid, running_id, started, finished,
                  finished_id, now, dropped, input ready);
  modport sink   (input valid, running_valid, running_id, started, finished,
                  finished_id, now, dropped, output ready);
endinterface

`default_nettype wire

// ===== src/sjf_store.sv =====
`default_nettype none

// Ready store: one write port, one read port, registered read data.
module sjf_store import sjf_pkg::*; (
  input  wire             clk_i,
  input  wire store_req_t req_i,
  output entry_t          rdata_o
);

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/sjf_out_reg.sv =====
`default_nettype none

// Output word register; frees when empty or being taken.
module sjf_out_reg import sjf_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              load_i,
  input  wire result_t     res_i,
  output logic             free_o,
  sjf_res_if.source        res_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign free_o  = !valid_q || res_o.ready;
  assign valid_d = load_i ? 1'b1 : (res_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.running_valid = data_q.running_valid;
  assign res_o.running_id    = data_q.running_id;
  assign res_o.started       = data_q.started;
  assign res_o.finished      = data_q.finished;
  assign res_o.finished_id   = data_q.finished_id;
  assign res_o.now           = data_q.now;
  assign res_o.dropped       = data_q.dropped;

endmodule

`default_nettype wire

// ===== src/sjf_nonpreemptive_scheduler.sv =====
`default_nettype none

// Channel  Dir  Word
// -------  ---  ---------------------------------------------------------------
// job_i    in   cmd (arrive/tick), job_id, burst
// res_o    out  running_valid, running_id, started, finished, finished_id,
//               now, dropped
//
// One word at a time. Arrive into an empty or full store: idle, then post;
// else one read-compare-shift step per cycle through the ready store for
// each stored job with a longer burst, then a write, then post. Tick: idle,
// take when a job leaves the store (twice when a zero-burst job taken from
// idle is replaced at once), post. A waiting result holds the post state and
// so stalls acceptance. Reset clears control state only; the store needs no
// clearing, only entries below the count are read.
module sjf_nonpreemptive_scheduler import sjf_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  sjf_job_if.sink   job_i,
  sjf_res_if.source res_o
);

  // Control state
  state_e state_q, state_d;

  // Ready store is a circular buffer kept sorted by burst from head_q
  logic [IdxW-1:0]   head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;

  // Running job
  logic              act_valid_q, act_valid_d;
  logic [IdW-1:0]    act_id_q, act_id_d;
  logic [BurstW-1:0] act_left_q, act_left_d;
  logic [TimeW-1:0]  time_q, time_d;

  // Insertion walk: slot being filled, compares left, job being placed
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   k_q, k_d;
  entry_t            new_q, new_d;

  // Second take in the same tick (replacement)
  logic              repl_q, repl_d;

  // Result being built
  result_t           res_q, res_d;

  store_req_t        req;
  entry_t            rdata;
  logic              out_free;
  logic              out_load;

  logic              accept;
  logic              is_tick;
  logic              full;
  logic [IdxW:0]     tail_sum;
  logic [IdxW-1:0]   tail;
  logic              rd_longer;
  logic              take_runs;

  sjf_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  sjf_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .res_i  (res_q),
    .free_o (out_free),
    .res_o  (res_o)
  );

  assign job_i.ready = (state_q == ST_IDLE);
  assign accept      = job_i.valid && job_i.ready;
  assign is_tick     = (job_i.cmd == CMD_TICK);
  assign full        = (count_q == CntW'(QUEUE_DEPTH));

  // First free slot behind the last stored job
  assign tail_sum = {1'b0, head_q} + (IdxW+1)'(count_q);
  assign tail     = (tail_sum >= (IdxW+1)'(QUEUE_DEPTH))
                  ? IdxW'(tail_sum - (IdxW+1)'(QUEUE_DEPTH))
                  : tail_sum[IdxW-1:0];

  // Stored job must move up when strictly longer (equal bursts keep order)
  assign rd_longer = (rdata.burst > new_q.burst);

  // Taken job runs this tick unless it is a zero-burst job taken from idle
  assign take_runs = repl_q || (rdata.burst != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!is_tick) begin
            if (full || count_q == '0) state_d = ST_POST;
            else state_d = ST_INS_CMP;
          end else if (act_valid_q && act_left_q != '0) begin
            state_d = ST_POST;
          end else if (count_q == '0) begin
            state_d = ST_POST;
          end else begin
            state_d = ST_TAKE;
          end
        end
      end
      ST_INS_CMP: begin
        if (!rd_longer) state_d = ST_POST;
        else if (k_q == CntW'(1)) state_d = ST_INS_PUT;
      end
      ST_INS_PUT: state_d = ST_POST;
      ST_TAKE: begin
        if (take_runs || count_q == CntW'(1)) state_d = ST_POST;
      end
      ST_POST: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and store accesses
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    act_valid_d = act_valid_q;
    act_id_d    = act_id_q;
    act_left_d  = act_left_q;
    time_d      = time_q;
    idx_d       = idx_q;
    k_d         = k_q;
    new_d       = new_q;
    repl_d      = repl_q;
    res_d       = res_q;
    out_load    = 1'b0;
    req         = '0;
    req.raddr   = head_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d     = '0;
          res_d.now = time_q;
          if (!is_tick) begin
            new_d = '{id: job_i.job_id, burst: job_i.burst};
            idx_d = tail;
            k_d   = count_q;
            if (full) begin
              res_d.dropped = 1'b1;
            end else if (count_q == '0) begin
              req.we    = 1'b1;
              req.waddr = tail;
              req.wdata = '{id: job_i.job_id, burst: job_i.burst};
              count_d   = count_q + CntW'(1);
            end else begin
              req.raddr = idx_prev(tail);
            end
          end else begin
            time_d = time_q + TimeW'(1);
            if (act_valid_q && act_left_q != '0) begin
              act_left_d          = act_left_q - BurstW'(1);
              res_d.running_valid = 1'b1;
              res_d.running_id    = act_id_q;
            end else if (act_valid_q) begin
              // Active job done: report it, then replace if anything waits
              res_d.finished    = 1'b1;
              res_d.finished_id = act_id_q;
              if (count_q == '0) begin
                act_valid_d = 1'b0;
                act_id_d    = '0;
              end else begin
                req.raddr = head_q;
                repl_d    = 1'b1;
              end
            end else if (count_q != '0) begin
              req.raddr = head_q;
              repl_d    = 1'b0;
            end
          end
        end
      end

      ST_INS_CMP: begin
        req.we = 1'b1;
        if (rd_longer) begin
          // Shift stored job up one slot, look at the next one down
          req.waddr = idx_q;
          req.wdata = rdata;
          idx_d     = idx_prev(idx_q);
          k_d       = k_q - CntW'(1);
          req.raddr = idx_prev(idx_prev(idx_q));
        end else begin
          req.waddr = idx_q;
          req.wdata = new_q;
          count_d   = count_q + CntW'(1);
        end
      end

      ST_INS_PUT: begin
        req.we    = 1'b1;
        req.waddr = idx_q;
        req.wdata = new_q;
        count_d   = count_q + CntW'(1);
      end

      ST_TAKE: begin
        head_d      = idx_next(head_q);
        count_d     = count_q - CntW'(1);
        act_valid_d = 1'b1;
        act_id_d    = rdata.id;
        act_left_d  = rdata.burst;
        if (take_runs) begin
          if (rdata.burst != '0) act_left_d = rdata.burst - BurstW'(1);
          res_d.started       = 1'b1;
          res_d.running_valid = 1'b1;
          res_d.running_id    = rdata.id;
        end else begin
          // Zero-burst job from idle finishes in the same tick
          res_d.finished    = 1'b1;
          res_d.finished_id = rdata.id;
          if (count_q == CntW'(1)) begin
            act_valid_d = 1'b0;
            act_id_d    = '0;
          end else begin
            req.raddr = idx_next(head_q);
            repl_d    = 1'b1;
          end
        end
      end

      ST_POST: begin
        out_load = out_free;
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      act_valid_q <= 1'b0;
      act_id_q    <= '0;
      act_left_q  <= '0;
      time_q      <= '0;
      repl_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      act_valid_q <= act_valid_d;
      act_id_q    <= act_id_d;
      act_left_q  <= act_left_d;
      time_q      <= time_d;
      repl_q      <= repl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    k_q   <= k_d;
    new_q <= new_d;
    res_q <= res_d;
  end

endmodule

`default_nettype wire
